FILE: src/tpw_pkg.sv
// ----------------------------------------------------------------------------
// tpw_pkg
// Shared types, entry bit positions and the access check for the walker.
// ----------------------------------------------------------------------------
package tpw_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PDE,
    ST_PTE
  } walk_state_t;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam int PRESENT_BIT = 0;
  localparam int RW_BIT      = 1;
  localparam int LARGE_BIT   = 7;

  localparam int MODE_READ_BIT  = 0;
  localparam int MODE_WRITE_BIT = 1;

  // A read check needs Present; a write check looks at RW alone.
  function automatic logic entry_check(input logic [31:0] entry, input logic [1:0] mode);
    logic ok;
    ok = 1'b1;
    if (mode[MODE_READ_BIT] && !entry[PRESENT_BIT]) begin
      ok = 1'b0;
    end
    if (mode[MODE_WRITE_BIT] && !entry[RW_BIT]) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

FILE: src/two_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// two_level_page_table_walker
// Two-level 32-bit page walk over a table store held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Timing: a write transfer completes in the accepting cycle and busy stays
// low. A look-up strobes its result in the cycle after acceptance when the
// directory word is out of the store, after the directory read for an absent
// or large-page entry or an out-of-store page-table word, and after both reads
// for a full walk; busy is high while the RAM is read, so the next transfer
// can be taken in the cycle of the strobe. The rate is set by the single RAM
// port: each level is one read. Synchronous active-low reset clears the walk
// state, the strobe and dir_frame, not the store. Results cannot be stalled.
// ----------------------------------------------------------------------------
module two_level_page_table_walker
  import tpw_pkg::*;
#(
  parameter int STORE_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  // Input command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [15:0] in_word_addr,
  input  logic [31:0] in_word_data,
  input  logic [31:0] in_virt_addr,
  input  logic [1:0]  in_access_mode,
  // Result channel
  output logic        out_strobe,
  output logic [31:0] out_phys_addr,
  output logic        out_mapped,
  output logic        out_access_ok,
  output logic        out_large_page,
  output logic        out_outside_window
);

  localparam int          ADDR_W    = $clog2(STORE_WORDS);
  // Limit held one bit wider than any table index so the compare is exact.
  localparam logic [30:0] STORE_LIM = 31'(STORE_WORDS);

  walk_state_t state_r, state_nxt;
  logic [19:0] dir_frame_r;
  logic [31:0] va_r, va_nxt;
  logic [1:0]  mode_r, mode_nxt;

  logic        out_strobe_r, out_strobe_nxt;
  logic [31:0] phys_r, phys_nxt;
  logic        mapped_r, mapped_nxt;
  logic        ok_r, ok_nxt;
  logic        large_r, large_nxt;
  logic        outside_r, outside_nxt;

  logic              accept;
  logic [31:0]       word_addr_ext;
  logic              word_in_store;
  logic [29:0]       pd_index;
  logic [29:0]       pt_index;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [31:0]       mem_rdata;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // The write address is widened first so that it suits any store depth.
  assign word_addr_ext = {16'b0, in_word_addr};
  assign word_in_store = ({1'b0, word_addr_ext[29:0]} < STORE_LIM);

  // Directory index from the incoming address; page-table index from the
  // directory entry that the RAM has just returned.
  assign pd_index = {dir_frame_r, in_virt_addr[31:22]};
  assign pt_index = {mem_rdata[31:12], va_r[21:12]};

  tpw_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_word_data),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_frame_r <= '0;
    end else if (cfg_we) begin
      dir_frame_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r      <= va_nxt;
    mode_r    <= mode_nxt;
    phys_r    <= phys_nxt;
    mapped_r  <= mapped_nxt;
    ok_r      <= ok_nxt;
    large_r   <= large_nxt;
    outside_r <= outside_nxt;
  end

  // Walk sequencer. Writes land in the RAM only while idle; a look-up issues
  // its directory read in an accepting cycle that writes nothing and its table
  // read in ST_PDE, so no read races a write and no forwarding is needed.
  always_comb begin
    state_nxt      = state_r;
    va_nxt         = va_r;
    mode_nxt       = mode_r;
    out_strobe_nxt = 1'b0;
    phys_nxt       = phys_r;
    mapped_nxt     = mapped_r;
    ok_nxt         = ok_r;
    large_nxt      = large_r;
    outside_nxt    = outside_r;
    mem_we         = 1'b0;
    mem_addr       = pd_index[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_WRITE) begin
            mem_addr = word_addr_ext[ADDR_W-1:0];
            mem_we   = word_in_store;
          end else begin
            va_nxt   = in_virt_addr;
            mode_nxt = in_access_mode;
            if ({1'b0, pd_index} >= STORE_LIM) begin
              // Directory word beyond the store: report at once.
              out_strobe_nxt = 1'b1;
              phys_nxt       = '0;
              mapped_nxt     = 1'b0;
              ok_nxt         = 1'b0;
              large_nxt      = 1'b0;
              outside_nxt    = 1'b1;
            end else begin
              state_nxt = ST_PDE;
            end
          end
        end
      end

      ST_PDE: begin
        mem_addr    = pt_index[ADDR_W-1:0];
        phys_nxt    = '0;
        mapped_nxt  = 1'b0;
        ok_nxt      = 1'b0;
        large_nxt   = 1'b0;
        outside_nxt = 1'b0;
        if (!mem_rdata[PRESENT_BIT]) begin
          // Absent directory entry fails every check, even an empty one.
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (mem_rdata[LARGE_BIT]) begin
          out_strobe_nxt = 1'b1;
          phys_nxt       = {mem_rdata[31:22], va_r[21:0]};
          mapped_nxt     = 1'b1;
          ok_nxt         = entry_check(mem_rdata, mode_r);
          large_nxt      = 1'b1;
          state_nxt      = ST_IDLE;
        end else if ({1'b0, pt_index} >= STORE_LIM) begin
          out_strobe_nxt = 1'b1;
          outside_nxt    = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_PTE;
        end
      end

      ST_PTE: begin
        out_strobe_nxt = 1'b1;
        // The check runs on the page-table entry even when it is absent.
        ok_nxt         = entry_check(mem_rdata, mode_r);
        large_nxt      = 1'b0;
        outside_nxt    = 1'b0;
        if (mem_rdata[PRESENT_BIT]) begin
          phys_nxt   = {mem_rdata[31:12], va_r[11:0]};
          mapped_nxt = 1'b1;
        end else begin
          phys_nxt   = '0;
          mapped_nxt = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_strobe         = out_strobe_r;
  assign out_phys_addr      = phys_r;
  assign out_mapped         = mapped_r;
  assign out_access_ok      = ok_r;
  assign out_large_page     = large_r;
  assign out_outside_window = outside_r;

  // A second-level read always ends in a result on the next cycle.
  a_pte_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PTE) |=> out_strobe_r)
    else $error("page-table read did not produce a result");

  // The second level is only ever entered from the first.
  a_pte_after_pde: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PTE) |-> $past(state_r == ST_PDE))
    else $error("page-table state entered without a directory read");

  // An out-of-store walk is never reported as mapped.
  a_outside_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_outside_window) |-> (!out_mapped && !out_large_page &&
                                             !out_access_ok && (out_phys_addr == 32'd0)))
    else $error("outside-window result carries a translation");

  // An unmapped result carries a zero physical address.
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_mapped) |-> (out_phys_addr == 32'd0))
    else $error("unmapped result with non-zero physical address");

  // The store is written only while no walk is in progress.
  a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE) && !out_strobe_nxt)
    else $error("table write during a walk");

endmodule

FILE: src/tpw_ram.sv
// ----------------------------------------------------------------------------
// tpw_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
